### rtl/core/touch_sample_average_map_assert.svh
// ----------------------------------------------------------------------------
// touch_sample_average_map assertion macros
// Shorthand for the concurrent checks in tsam_back.
// ----------------------------------------------------------------------------
`ifndef TOUCH_SAMPLE_AVERAGE_MAP_ASSERT_SVH
`define TOUCH_SAMPLE_AVERAGE_MAP_ASSERT_SVH

// same-cycle implication
`define TSAM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsam: assertion failed");

// next-cycle implication
`define TSAM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsam: assertion failed");

`endif

### rtl/core/tsam_pkg.sv
// ----------------------------------------------------------------------------
// tsam_pkg
// Shared types, constants and helpers of the touch averaging/mapping core.
// ----------------------------------------------------------------------------
package tsam_pkg;

   localparam int unsigned SAMPLE_COUNT_DEF = 8;
   localparam int unsigned SAMPLE_COUNT_MAX = 64;

   localparam int unsigned RAW_W   = 12;
   localparam int unsigned SIZE_W  = 13;
   localparam int unsigned PRESS_W = 13;
   localparam int unsigned PIX_W   = 12;

   // four channels: X, Y, Z1, Z2
   localparam int unsigned CHANNELS = 4;
   localparam int unsigned CH_W     = 2;
   localparam logic [CH_W-1:0] CH_X  = 2'd0;
   localparam logic [CH_W-1:0] CH_Y  = 2'd1;
   localparam logic [CH_W-1:0] CH_Z1 = 2'd2;
   localparam logic [CH_W-1:0] CH_Z2 = 2'd3;

   // sums sized for the largest supported sample count
   localparam int unsigned SUM_MAX_W = $clog2(SAMPLE_COUNT_MAX * 4095 + 1);

   // divider: the mapping quotient always fits in 12 bits
   localparam int unsigned DIV_Q_W   = 12;
   localparam int unsigned DIV_DEN_W = 12;
   localparam int unsigned DIV_NUM_W = DIV_Q_W + DIV_DEN_W;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [PRESS_W-1:0] PRESS_OFFSET = 13'd4095;
   localparam logic [SIZE_W-1:0]  SIZE_LIMIT   = 13'd4096;

   // register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_X_MIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_MAX     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_MIN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_MAX     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd6;
   localparam int unsigned CSR_DATA_W = 13;

   typedef struct packed {
      logic             pen_down;
      logic [RAW_W-1:0] sample_x;
      logic [RAW_W-1:0] sample_y;
      logic [RAW_W-1:0] sample_z1;
      logic [RAW_W-1:0] sample_z2;
   } req_data_type;

   typedef struct packed {
      logic               touched;
      logic [PIX_W-1:0]   pixel_x;
      logic [PIX_W-1:0]   pixel_y;
      logic [PRESS_W-1:0] pressure;
   } rsp_data_type;

   typedef struct packed {
      logic [RAW_W-1:0]   x_raw_min;
      logic [RAW_W-1:0]   x_raw_max;
      logic [RAW_W-1:0]   y_raw_min;
      logic [RAW_W-1:0]   y_raw_max;
      logic [SIZE_W-1:0]  screen_width;
      logic [SIZE_W-1:0]  screen_height;
      logic [PRESS_W-1:0] pressure_threshold;
   } cfg_type;

   typedef enum logic {
      JOB_PEN_UP,
      JOB_SET
   } job_kind_type;

   typedef struct packed {
      job_kind_type                         kind;
      logic [CHANNELS-1:0][SUM_MAX_W-1:0]   sum;
   } job_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DIV_Q_W-1:0] quot;
   } div_rsp_type;

   // last pixel index; size 0 acts as 1, sizes above 4096 act as 4096
   function automatic logic [PIX_W-1:0] size_to_last(input logic [SIZE_W-1:0] size);
      logic [PIX_W-1:0] last;
      if (size == '0) begin
         last = '0;
      end else if (size > SIZE_LIMIT) begin
         last = '1;
      end else begin
         last = PIX_W'(size - SIZE_W'(1));
      end
      return last;
   endfunction

endpackage

### rtl/core/tsam_queue.sv
// ----------------------------------------------------------------------------
// tsam_queue
// Short job queue between the accumulating front and the compute back.
// ----------------------------------------------------------------------------
module tsam_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tsam_pkg::job_type push_data,
   input  logic              pop,
   output tsam_pkg::job_type head,
   output logic              full,
   output logic              empty
);
   import tsam_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   assign full  = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/tsam_front.sv
// ----------------------------------------------------------------------------
// tsam_front
// Takes conversion sets, keeps the running sums and queues a job on pen up
// or when a full set of samples has been summed.
// ----------------------------------------------------------------------------
module tsam_front #(
   parameter int unsigned SAMPLE_COUNT = tsam_pkg::SAMPLE_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tsam_pkg::req_data_type req_data,
   input  logic                   q_full,
   output logic                   q_push,
   output tsam_pkg::job_type      q_job
);
   import tsam_pkg::*;

   localparam int unsigned SUM_W = $clog2(SAMPLE_COUNT * 4095 + 1);
   localparam int unsigned CNT_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;

   logic [SUM_W-1:0] sum_ff [CHANNELS];
   logic [SUM_W-1:0] sum_in [CHANNELS];
   logic [SUM_W-1:0] sum_add [CHANNELS];
   logic [RAW_W-1:0] sample [CHANNELS];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;
   logic             set_done;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign set_done  = (cnt_ff == CNT_W'(SAMPLE_COUNT-1));

   assign sample[CH_X]  = req_data.sample_x;
   assign sample[CH_Y]  = req_data.sample_y;
   assign sample[CH_Z1] = req_data.sample_z1;
   assign sample[CH_Z2] = req_data.sample_z2;

   always_comb begin
      q_push   = accept && (!req_data.pen_down || set_done);
      q_job    = '0;
      q_job.kind = req_data.pen_down ? JOB_SET : JOB_PEN_UP;
      cnt_in   = cnt_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         sum_add[i]   = sum_ff[i] + SUM_W'(sample[i]);
         sum_in[i]    = sum_ff[i];
         q_job.sum[i] = SUM_MAX_W'(sum_add[i]);
      end
      if (accept) begin
         if (!req_data.pen_down || set_done) begin
            cnt_in = '0;
            for (int i = 0; i < CHANNELS; i++) begin
               sum_in[i] = '0;
            end
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
            for (int i = 0; i < CHANNELS; i++) begin
               sum_in[i] = sum_add[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         cnt_ff <= cnt_in;
         for (int i = 0; i < CHANNELS; i++) begin
            sum_ff[i] <= sum_in[i];
         end
      end
   end

endmodule

### rtl/core/tsam_div.sv
// ----------------------------------------------------------------------------
// tsam_div
// Restoring divider, one quotient bit per cycle. The caller guarantees
// num < den * 2**DIV_Q_W, so the quotient fits and 12 steps suffice.
// ----------------------------------------------------------------------------
module tsam_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tsam_pkg::div_req_type req,
   output tsam_pkg::div_rsp_type rsp
);
   import tsam_pkg::*;

   localparam int unsigned STEP_W = $clog2(DIV_Q_W + 1);

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_Q_W-1:0]   low_ff, low_in;
   logic [DIV_Q_W-1:0]   quot_ff, quot_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   assign trial = {rem_ff, low_ff[DIV_Q_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.num[DIV_NUM_W-1:DIV_Q_W];
         low_in  = req.num[DIV_Q_W-1:0];
         den_in  = req.den;
         quot_in = '0;
         step_in = STEP_W'(DIV_Q_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         low_in  = {low_ff[DIV_Q_W-2:0], 1'b0};
         quot_in = {quot_ff[DIV_Q_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

### rtl/core/tsam_back.sv
// ----------------------------------------------------------------------------
// tsam_back
// Sequencer that averages a queued set, checks pressure, maps X and Y to
// pixels via the shared divider and holds the result register (all zero on pen-up).
// ----------------------------------------------------------------------------
`include "touch_sample_average_map_assert.svh"

module tsam_back #(
   parameter int unsigned SAMPLE_COUNT = tsam_pkg::SAMPLE_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tsam_pkg::cfg_type      cfg,
   input  logic                   q_empty,
   input  tsam_pkg::job_type      q_head,
   output logic                   q_pop,
   output tsam_pkg::div_req_type  div_req,
   input  tsam_pkg::div_rsp_type  div_rsp,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tsam_pkg::rsp_data_type rsp_data
);
   import tsam_pkg::*;

   // average = (sum * AVG_MULT) >> AVG_SHIFT, exact for every sum below 2**SUM_MAX_W
   localparam int unsigned AVG_SHIFT = SUM_MAX_W + $clog2(SAMPLE_COUNT);
   localparam int unsigned MULT_W    = SUM_MAX_W + 2;
   localparam int unsigned PROD_W    = SUM_MAX_W + MULT_W;
   localparam logic [MULT_W-1:0] AVG_MULT =
      MULT_W'(((1 << AVG_SHIFT) + SAMPLE_COUNT - 1) / SAMPLE_COUNT);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG,
      ST_PRESS,
      ST_MAP,
      ST_MAP_DIV,
      ST_MAP_WAIT,
      ST_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [CH_W-1:0]      idx_ff, idx_in;
   logic                 axis_ff, axis_in;
   logic [SUM_MAX_W-1:0] sum_ff [CHANNELS];
   logic [SUM_MAX_W-1:0] sum_in [CHANNELS];
   logic [RAW_W-1:0]     avg_ff [CHANNELS];
   logic [RAW_W-1:0]     avg_in [CHANNELS];
   logic [DIV_NUM_W-1:0] prod_ff, prod_in;
   logic [DIV_DEN_W-1:0] mden_ff, mden_in;
   rsp_data_type         res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_data_type         rsp_data_ff, rsp_data_in;

   logic [PROD_W-1:0]    avg_prod;
   logic [PRESS_W-1:0]   press;
   logic [RAW_W-1:0]     raw_sel, lo_sel, hi_sel;
   logic [PIX_W-1:0]     last_sel;
   logic                 pix_wr;
   logic [PIX_W-1:0]     pix_val;
   logic                 advance;

   assign avg_prod = sum_ff[idx_ff] * AVG_MULT;
   assign press    = PRESS_W'(avg_ff[CH_Z1]) + PRESS_OFFSET - PRESS_W'(avg_ff[CH_Z2]);
   assign raw_sel  = axis_ff ? avg_ff[CH_Y] : avg_ff[CH_X];
   assign lo_sel   = axis_ff ? cfg.y_raw_min : cfg.x_raw_min;
   assign hi_sel   = axis_ff ? cfg.y_raw_max : cfg.x_raw_max;
   assign last_sel = size_to_last(axis_ff ? cfg.screen_height : cfg.screen_width);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      axis_in      = axis_ff;
      prod_in      = prod_ff;
      mden_in      = mden_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      div_req      = '0;
      pix_wr       = 1'b0;
      pix_val      = '0;
      advance      = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
         sum_in[i] = sum_ff[i];
         avg_in[i] = avg_ff[i];
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_head.kind == JOB_PEN_UP) begin
                  res_in   = '0;
                  state_in = ST_EMIT;
               end else begin
                  for (int i = 0; i < CHANNELS; i++) begin
                     sum_in[i] = q_head.sum[i];
                  end
                  idx_in   = CH_X;
                  state_in = ST_AVG;
               end
            end
         end
         ST_AVG: begin
            avg_in[idx_ff] = avg_prod[AVG_SHIFT +: RAW_W];
            if (idx_ff == CH_Z2) begin
               state_in = ST_PRESS;
            end else begin
               idx_in = idx_ff + CH_W'(1);
            end
         end
         ST_PRESS: begin
            if (press < cfg.pressure_threshold) begin
               res_in   = '0;
               state_in = ST_EMIT;
            end else begin
               res_in          = '0;
               res_in.touched  = 1'b1;
               res_in.pressure = press;
               axis_in         = 1'b0;
               state_in        = ST_MAP;
            end
         end
         ST_MAP: begin
            if (raw_sel <= lo_sel) begin
               pix_wr  = 1'b1;
               pix_val = '0;
               advance = 1'b1;
            end else if (raw_sel >= hi_sel) begin
               pix_wr  = 1'b1;
               pix_val = last_sel;
               advance = 1'b1;
            end else begin
               prod_in  = DIV_NUM_W'(raw_sel - lo_sel) * DIV_NUM_W'(last_sel);
               mden_in  = hi_sel - lo_sel;
               state_in = ST_MAP_DIV;
            end
         end
         ST_MAP_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = prod_ff;
            div_req.den   = mden_ff;
            state_in      = ST_MAP_WAIT;
         end
         ST_MAP_WAIT: begin
            if (div_rsp.done) begin
               pix_wr  = 1'b1;
               pix_val = div_rsp.quot;
               advance = 1'b1;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (pix_wr) begin
         if (axis_ff) begin
            res_in.pixel_y = pix_val;
         end else begin
            res_in.pixel_x = pix_val;
         end
      end
      if (advance) begin
         if (axis_ff) begin
            state_in = ST_EMIT;
         end else begin
            axis_in  = 1'b1;
            state_in = ST_MAP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      axis_ff     <= axis_in;
      prod_ff     <= prod_in;
      mden_ff     <= mden_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < CHANNELS; i++) begin
         sum_ff[i] <= sum_in[i];
         avg_ff[i] <= avg_in[i];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // divider finishes only while the sequencer waits for it
   `TSAM_ASSERT_NOW(a_done_in_wait, clock, reset, div_rsp.done, state_ff == ST_MAP_WAIT)
   // a divider launch is seen busy on the next cycle
   `TSAM_ASSERT_NEXT(a_start_busy, clock, reset, state_ff == ST_MAP_DIV, div_rsp.busy)
   // an untouched result (pen-up or rejected touch) carries all-zero fields
   `TSAM_ASSERT_NOW(a_untouched_zero, clock, reset, rsp_valid_ff && !rsp_data_ff.touched,
      rsp_data_ff.pixel_x == '0 && rsp_data_ff.pixel_y == '0 && rsp_data_ff.pressure == '0)
   // a taken result is dropped unless a new one is loaded
   `TSAM_ASSERT_NEXT(a_taken_drops, clock, reset,
      rsp_valid_ff && !rsp_stall && state_ff != ST_EMIT, !rsp_valid_ff)

endmodule

### rtl/core/touch_sample_average_map.sv
// ----------------------------------------------------------------------------
// touch_sample_average_map
// Averaging, pressure check and screen calibration for a resistive touch panel.
// ----------------------------------------------------------------------------
// Input channel req_*: one conversion set (X, Y, Z1, Z2) plus pen-down flag per
// transaction. Output channel rsp_*: one result per pen-up transaction and one
// per SAMPLE_COUNT pen-down transactions; other transactions give none.
// Config channel csr_*: register writes, ready always high; the user writes
// only while idle, and the block does not enforce it. Sums are updated in the
// cycle a transaction is taken; a pen-up result or a completed set goes
// through a two-entry job queue to the compute sequencer. A pen-up job passes
// the queue to the emit step; a set is averaged (four averages, one channel
// per cycle, by reciprocal multiply) and pressure-checked, a rejected touch
// goes to emit, and each mapped axis clamps or uses the shared 12-step divider.
// req_stall rises only when the job queue is full, e.g. under a burst of
// pen-ups, which the sequencer retires through its idle and emit steps.
// While a result waits under rsp_stall the sequencer works on the next job
// and holds in its emit step; the waiting result stays steady until taken.
// Reset: sums, set count and queue clear, registers take their defaults
// (raw range 0..4095, 320 x 240 pixels, threshold 100).
// ----------------------------------------------------------------------------
module touch_sample_average_map #(
   parameter int unsigned SAMPLE_COUNT = tsam_pkg::SAMPLE_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tsam_pkg::req_data_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tsam_pkg::rsp_data_type               rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tsam_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tsam_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tsam_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        q_push, q_pop, q_full, q_empty;
   job_type     q_job, q_head;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_X_MIN:     cfg_in.x_raw_min          = csr_wdata[RAW_W-1:0];
            CSR_X_MAX:     cfg_in.x_raw_max          = csr_wdata[RAW_W-1:0];
            CSR_Y_MIN:     cfg_in.y_raw_min          = csr_wdata[RAW_W-1:0];
            CSR_Y_MAX:     cfg_in.y_raw_max          = csr_wdata[RAW_W-1:0];
            CSR_WIDTH:     cfg_in.screen_width       = csr_wdata[SIZE_W-1:0];
            CSR_HEIGHT:    cfg_in.screen_height      = csr_wdata[SIZE_W-1:0];
            CSR_THRESHOLD: cfg_in.pressure_threshold = csr_wdata[PRESS_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_raw_min          <= RAW_W'(0);
         cfg_ff.x_raw_max          <= RAW_W'(4095);
         cfg_ff.y_raw_min          <= RAW_W'(0);
         cfg_ff.y_raw_max          <= RAW_W'(4095);
         cfg_ff.screen_width       <= SIZE_W'(320);
         cfg_ff.screen_height      <= SIZE_W'(240);
         cfg_ff.pressure_threshold <= PRESS_W'(100);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsam_front #(
      .SAMPLE_COUNT (SAMPLE_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (q_job)
   );

   tsam_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_job),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   tsam_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   tsam_back #(
      .SAMPLE_COUNT (SAMPLE_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for touch_sample_average_map: pen-up and conversion-set
// transactions with random content and random idling on both channels; a
// local model of averaging, pressure check and screen mapping predicts every
// report, and calibration registers are swept between idle phases.
// ----------------------------------------------------------------------------
module testbench;
   import tsam_pkg::*;

   localparam int unsigned CYCLE_LIMIT    = 400000;
   localparam int unsigned SETTLE_CYCLES  = 120;
   localparam int unsigned END_WAIT_LIMIT = 20000;
   localparam int unsigned HOLD_OFF_LEN   = 400;
   localparam int unsigned MAX_PAUSE      = 17;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_data_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_data_type          rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // model state: calibration registers and running sums
   cfg_type                cal;
   logic [SUM_MAX_W-1:0]   acc_x, acc_y, acc_z1, acc_z2;
   int unsigned            sets_summed;
   rsp_data_type           expected_reports[$];

   bit          tx_idle_on;
   bit          rx_idle_on;
   int unsigned hold_off_cycles;
   int unsigned cycle_count;
   int unsigned mismatches;
   int unsigned items_sent;
   int unsigned pen_ups_sent;
   int unsigned reports_checked;
   int unsigned touches_seen;
   int unsigned csr_writes;
   int unsigned settings_used;

   touch_sample_average_map DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model

   function automatic logic [PIX_W-1:0] to_pixel(input logic [RAW_W-1:0] raw, lo, hi,
                                                 input logic [SIZE_W-1:0] span);
      logic [PIX_W-1:0] last;
      logic [23:0]      scaled;
      if (span == '0) begin
         last = '0;
      end else if (span >= 13'd4096) begin
         last = 12'd4095;
      end else begin
         last = span[PIX_W-1:0] - 1'b1;
      end
      if (raw <= lo) return '0;
      if (raw >= hi) return last;
      scaled = ({12'd0, raw - lo} * {12'd0, last}) / {12'd0, hi - lo};
      return scaled[PIX_W-1:0];
   endfunction

   function automatic void clear_sums();
      acc_x = '0;
      acc_y = '0;
      acc_z1 = '0;
      acc_z2 = '0;
      sets_summed = 0;
   endfunction

   // returns 1 when the transaction produces a report
   function automatic bit track_touch(input req_data_type item, output rsp_data_type rpt);
      logic [SUM_MAX_W-1:0] avg_x, avg_y, avg_z1, avg_z2;
      logic [PRESS_W-1:0]   press;
      rpt = '0;
      if (!item.pen_down) begin
         clear_sums();
         return 1'b1;
      end
      acc_x  = acc_x + item.sample_x;
      acc_y  = acc_y + item.sample_y;
      acc_z1 = acc_z1 + item.sample_z1;
      acc_z2 = acc_z2 + item.sample_z2;
      sets_summed++;
      if (sets_summed < SAMPLE_COUNT_DEF) return 1'b0;
      avg_x  = acc_x / SUM_MAX_W'(SAMPLE_COUNT_DEF);
      avg_y  = acc_y / SUM_MAX_W'(SAMPLE_COUNT_DEF);
      avg_z1 = acc_z1 / SUM_MAX_W'(SAMPLE_COUNT_DEF);
      avg_z2 = acc_z2 / SUM_MAX_W'(SAMPLE_COUNT_DEF);
      clear_sums();
      press = {1'b0, avg_z1[RAW_W-1:0]} + PRESS_OFFSET - {1'b0, avg_z2[RAW_W-1:0]};
      if (press < cal.pressure_threshold) return 1'b1;
      rpt.touched  = 1'b1;
      rpt.pixel_x  = to_pixel(avg_x[RAW_W-1:0], cal.x_raw_min, cal.x_raw_max, cal.screen_width);
      rpt.pixel_y  = to_pixel(avg_y[RAW_W-1:0], cal.y_raw_min, cal.y_raw_max,
                              cal.screen_height);
      rpt.pressure = press;
      return 1'b1;
   endfunction

   // ------------------------------------------------------------- checking

   task automatic flag_mismatch(input string msg);
      if (mismatches < 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin : check_reports
      rsp_data_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         reports_checked++;
         if (expected_reports.size() == 0) begin
            flag_mismatch($sformatf("report %0d with nothing expected: %p", reports_checked,
                                    rsp_data));
         end else begin
            want = expected_reports.pop_front();
            if (want.touched) touches_seen++;
            if (rsp_data.touched !== want.touched)
               flag_mismatch($sformatf("report %0d touched: expected %0d, got %0d",
                                       reports_checked, want.touched, rsp_data.touched));
            if (rsp_data.pixel_x !== want.pixel_x)
               flag_mismatch($sformatf("report %0d pixel_x: expected %0d, got %0d",
                                       reports_checked, want.pixel_x, rsp_data.pixel_x));
            if (rsp_data.pixel_y !== want.pixel_y)
               flag_mismatch($sformatf("report %0d pixel_y: expected %0d, got %0d",
                                       reports_checked, want.pixel_y, rsp_data.pixel_y));
            if (rsp_data.pressure !== want.pressure)
               flag_mismatch($sformatf("report %0d pressure: expected %0d, got %0d",
                                       reports_checked, want.pressure, rsp_data.pressure));
         end
      end
   end

   // ------------------------------------------------------------- receiver

   function automatic int unsigned rx_pause();
      return rx_idle_on ? $urandom_range(0, MAX_PAUSE) : 0;
   endfunction

   initial begin : drive_rsp_stall
      int unsigned pause;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end
         pause = rx_pause();
         if (pause != 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         forever begin
            @(posedge clock);
            if (rsp_valid === 1'b1 || hold_off_cycles != 0) break;
         end
      end
   end

   // --------------------------------------------------------------- sender

   function automatic logic [RAW_W-1:0] any_raw();
      return RAW_W'($urandom_range(0, 4095));
   endfunction

   function automatic logic [RAW_W-1:0] jitter_around(input int base, input int spread);
      int v;
      v = base + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[RAW_W-1:0];
   endfunction

   function automatic req_data_type sample(input logic pen, input logic [RAW_W-1:0] x, y,
                                           z1, z2);
      req_data_type s;
      s.pen_down  = pen;
      s.sample_x  = x;
      s.sample_y  = y;
      s.sample_z1 = z1;
      s.sample_z2 = z2;
      return s;
   endfunction

   function automatic req_data_type pen_up_noise();
      return sample(1'b0, any_raw(), any_raw(), any_raw(), any_raw());
   endfunction

   function automatic logic [RAW_W-1:0] pick_center(input logic [RAW_W-1:0] lo, hi);
      case ($urandom_range(0, 3))
         0:       return jitter_around(int'(lo), 4);
         1:       return jitter_around(int'(hi), 4);
         default: return any_raw();
      endcase
   endfunction

   task automatic send_sample(input req_data_type item);
      int unsigned  gap;
      rsp_data_type rpt;
      gap = tx_idle_on ? $urandom_range(0, MAX_PAUSE) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (!item.pen_down) pen_ups_sent++;
      if (track_touch(item, rpt)) expected_reports.push_back(rpt);
   endtask

   // count pen-down conversions around a common touch point
   task automatic send_touch_set(input int unsigned count);
      logic [RAW_W-1:0] cx, cy, cz1, cz2;
      cx  = pick_center(cal.x_raw_min, cal.x_raw_max);
      cy  = pick_center(cal.y_raw_min, cal.y_raw_max);
      cz2 = any_raw();
      // half the sets land near the pressure threshold
      if ($urandom_range(0, 1) == 1)
         cz1 = jitter_around(int'(cz2) + int'(cal.pressure_threshold) - 4095, 6);
      else
         cz1 = any_raw();
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 7) == 0)
            send_sample(sample(1'b1, any_raw(), any_raw(), any_raw(), any_raw()));
         else
            send_sample(sample(1'b1, jitter_around(int'(cx), 3), jitter_around(int'(cy), 3),
                               jitter_around(int'(cz1), 2), jitter_around(int'(cz2), 2)));
      end
   endtask

   task automatic send_random_traffic(input int unsigned n);
      int unsigned goal;
      goal = items_sent + n;
      while (items_sent < goal) begin
         case ($urandom_range(0, 19))
            0, 1, 2: send_sample(pen_up_noise());
            3, 4: begin
               send_touch_set($urandom_range(1, SAMPLE_COUNT_DEF - 1));
               send_sample(pen_up_noise());
            end
            // leaves a partial set behind so later sets are misaligned
            5:       send_touch_set($urandom_range(1, SAMPLE_COUNT_DEF - 1));
            default: send_touch_set(SAMPLE_COUNT_DEF);
         endcase
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------ registers

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
      case (idx)
         CSR_X_MIN:     cal.x_raw_min          = value[RAW_W-1:0];
         CSR_X_MAX:     cal.x_raw_max          = value[RAW_W-1:0];
         CSR_Y_MIN:     cal.y_raw_min          = value[RAW_W-1:0];
         CSR_Y_MAX:     cal.y_raw_max          = value[RAW_W-1:0];
         CSR_WIDTH:     cal.screen_width       = value;
         CSR_HEIGHT:    cal.screen_height      = value;
         CSR_THRESHOLD: cal.pressure_threshold = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic cfg_type make_calibration(input logic [RAW_W-1:0] x_lo, x_hi, y_lo,
                                                y_hi, input logic [SIZE_W-1:0] w, h, thr);
      cfg_type c;
      c.x_raw_min          = x_lo;
      c.x_raw_max          = x_hi;
      c.y_raw_min          = y_lo;
      c.y_raw_max          = y_hi;
      c.screen_width       = w;
      c.screen_height      = h;
      c.pressure_threshold = thr;
      return c;
   endfunction

   function automatic cfg_type random_calibration();
      cfg_type c;
      c.x_raw_min = any_raw();
      c.x_raw_max = ($urandom_range(0, 4) != 0) ? RAW_W'($urandom_range(c.x_raw_min, 4095))
                                                 : any_raw();
      c.y_raw_min = any_raw();
      c.y_raw_max = ($urandom_range(0, 4) != 0) ? RAW_W'($urandom_range(c.y_raw_min, 4095))
                                                 : any_raw();
      c.screen_width  = ($urandom_range(0, 3) != 0) ? SIZE_W'($urandom_range(1, 4096))
                                                     : SIZE_W'($urandom_range(0, 8191));
      c.screen_height = ($urandom_range(0, 3) != 0) ? SIZE_W'($urandom_range(1, 4096))
                                                     : SIZE_W'($urandom_range(0, 8191));
      c.pressure_threshold = ($urandom_range(0, 3) != 0)
                             ? PRESS_W'($urandom_range(3000, 5200))
                             : PRESS_W'($urandom_range(0, 8191));
      return c;
   endfunction

   // raw registers get a random top bit that the block has to drop
   task automatic apply_calibration(input cfg_type c);
      wait_drained();
      write_register(CSR_X_MIN, {1'($urandom_range(0, 1)), c.x_raw_min});
      write_register(CSR_X_MAX, {1'($urandom_range(0, 1)), c.x_raw_max});
      write_register(CSR_Y_MIN, {1'($urandom_range(0, 1)), c.y_raw_min});
      write_register(CSR_Y_MAX, {1'($urandom_range(0, 1)), c.y_raw_max});
      write_register(CSR_WIDTH, c.screen_width);
      write_register(CSR_HEIGHT, c.screen_height);
      write_register(CSR_THRESHOLD, c.pressure_threshold);
      settings_used++;
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed_extremes();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      send_sample(sample(1'b0, '0, '0, '0, '0));
      // truncating averages, strongest pressure, lowest corner
      for (int i = 0; i < SAMPLE_COUNT_DEF; i++)
         send_sample(sample(1'b1, RAW_W'(i % 2), '0, '1, RAW_W'(i % 2)));
      // weak pressure at the far corner
      for (int i = 0; i < SAMPLE_COUNT_DEF; i++)
         send_sample(sample(1'b1, '1, '1, '0, '1));
      // set abandoned by a pen-up that carries all-ones fields
      for (int i = 0; i < 3; i++)
         send_sample(sample(1'b1, any_raw(), any_raw(), any_raw(), any_raw()));
      send_sample(sample(1'b0, '1, '1, '1, '1));
   endtask

   task automatic test_calibration_sweep();
      cfg_type settings[$];
      settings.push_back(make_calibration(12'd0, 12'd4095, 12'd0, 12'd4095,
                                          13'd4096, 13'd4096, 13'd0));
      // min equal to max on X, min above max on Y
      settings.push_back(make_calibration(12'd2048, 12'd2048, 12'd4095, 12'd0,
                                          13'd1, 13'd8191, 13'd8190));
      settings.push_back(make_calibration(12'd100, 12'd3900, 12'd200, 12'd3800,
                                          13'd0, 13'd0, 13'd4095));
      // threshold out of reach: every set is rejected
      settings.push_back(make_calibration(12'd1000, 12'd1001, 12'd4094, 12'd4095,
                                          13'd4097, 13'd4095, 13'd8191));
      settings.push_back(make_calibration(12'd0, 12'd0, 12'd4095, 12'd4095,
                                          13'd2, 13'd3, 13'd4000));
      settings.push_back(make_calibration(12'd300, 12'd3800, 12'd250, 12'd3900,
                                          13'd320, 13'd240, 13'd100));
      repeat (4) settings.push_back(random_calibration());
      foreach (settings[i]) begin
         apply_calibration(settings[i]);
         if (i == 5) write_register(CSR_UNUSED, CSR_DATA_W'($urandom_range(0, 8191)));
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         send_random_traffic(28);
      end
   endtask

   task automatic test_backpressure();
      wait_drained();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      hold_off_cycles = HOLD_OFF_LEN;
      repeat (6) send_sample(pen_up_noise());
      send_touch_set(SAMPLE_COUNT_DEF);
      send_touch_set(SAMPLE_COUNT_DEF);
      repeat (8) send_sample(pen_up_noise());
      wait_drained();
   endtask

   task automatic test_random_traffic();
      repeat (7) begin
         apply_calibration(random_calibration());
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         send_random_traffic(14);
         if ($urandom_range(0, 1) == 1) wait_drained();
         send_random_traffic(14);
      end
   endtask

   task automatic finish_run();
      int unsigned waited;
      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (expected_reports.size() != 0 && waited < END_WAIT_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_reports.size() != 0)
         flag_mismatch($sformatf("%0d expected reports never arrived",
                                 expected_reports.size()));
      $display("covered %0d input transactions (%0d pen-up) over %0d calibration settings",
               items_sent, pen_ups_sent, settings_used);
      $display("checked %0d reports, %0d accepted touches, %0d register writes, %0d errors",
               reports_checked, touches_seen, csr_writes, mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_X_MIN;
      csr_wdata       = '0;
      tx_idle_on      = 1'b0;
      rx_idle_on      = 1'b0;
      hold_off_cycles = 0;
      cycle_count     = 0;
      mismatches      = 0;
      items_sent      = 0;
      pen_ups_sent    = 0;
      reports_checked = 0;
      touches_seen    = 0;
      csr_writes      = 0;
      settings_used   = 1;
      cal = make_calibration(12'd0, 12'd4095, 12'd0, 12'd4095, 13'd320, 13'd240, 13'd100);
      clear_sums();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_calibration_sweep();
      test_backpressure();
      test_random_traffic();
      finish_run();
   end

endmodule

### touch_sample_average_map.f
+incdir+rtl/core
rtl/core/tsam_pkg.sv
rtl/core/tsam_queue.sv
rtl/core/tsam_front.sv
rtl/core/tsam_div.sv
rtl/core/tsam_back.sv
rtl/core/touch_sample_average_map.sv
tb/testbench.sv
